>>> src/vna_pkg.sv
package vna_pkg;

  // Field widths fixed by the item format.
  localparam int POS_W   = 24;
  localparam int DIFF_W  = 25;
  localparam int PROD_W  = 50;
  localparam int CROSS_W = 51;
  localparam int MAG_W   = 30;
  localparam int NORM_W  = 16;
  localparam int IDX_W   = 12;

  // Item function codes.
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_FACE = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // Status of a multi-cycle arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> src/vertex_normal_accumulator_core.sv
// Area-weighted vertex normals. A load beat (func 0) writes a vertex position and clears
// its normal sum with no stall. A face beat (func 1) keeps the input stalled through
// three reads of the single-port position memory, seven steps of the shared 25x25
// multiplier for the cross product and its done flag, then a read-modify-write of the
// single-port sum memory for each corner in turn. A read beat (func 2) keeps the input
// stalled through a right shift (at most SUM_WIDTH - 30 places) that brings the largest
// magnitude under 2^30, the bit-serial square root and the three divisions. A zero sum
// skips the shift, square root and divisions. A read waits in its output state while the
// previous result is still stalled in the output register; otherwise a result waits there
// while the next beat is taken. Out-of-range indexes and func 3 are dropped without a
// result.
module vertex_normal_accumulator_core #(
  parameter int MAX_VERTICES = 4096,
  parameter int SUM_WIDTH    = 56
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_func,
  input  logic [vna_pkg::IDX_W-1:0]          in_index_a,
  input  logic [vna_pkg::IDX_W-1:0]          in_index_b,
  input  logic [vna_pkg::IDX_W-1:0]          in_index_c,
  input  logic signed [vna_pkg::POS_W-1:0]   in_pos_in_x,
  input  logic signed [vna_pkg::POS_W-1:0]   in_pos_in_y,
  input  logic signed [vna_pkg::POS_W-1:0]   in_pos_in_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [vna_pkg::NORM_W-1:0]  out_normal_x,
  output logic signed [vna_pkg::NORM_W-1:0]  out_normal_y,
  output logic signed [vna_pkg::NORM_W-1:0]  out_normal_z,
  output logic                               out_sum_clipped
);

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int XW    = (AW > vna_pkg::IDX_W) ? AW : vna_pkg::IDX_W;
  localparam int SW    = SUM_WIDTH;
  localparam int ACC_W = 3 * SW + 1;
  localparam int POSM  = 3 * vna_pkg::POS_W;
  localparam int CW    = vna_pkg::CROSS_W;
  localparam int NW    = vna_pkg::NORM_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PB    = 4'd1;
  localparam logic [3:0] S_PC    = 4'd2;
  localparam logic [3:0] S_PW    = 4'd3;
  localparam logic [3:0] S_CROSS = 4'd4;
  localparam logic [3:0] S_ARD   = 4'd5;
  localparam logic [3:0] S_AWR   = 4'd6;
  localparam logic [3:0] S_RACC  = 4'd7;
  localparam logic [3:0] S_RNORM = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic              in_fire;
  logic [XW-1:0]     ext_a, ext_b, ext_c;
  logic              ok_a, ok_b, ok_c;
  logic [AW-1:0]     idx_a_r, idx_b_r, idx_c_r;
  logic [1:0]        corner_r;
  logic [AW-1:0]     corner_idx;

  logic [POSM-1:0]   pos_mem [MAX_VERTICES];
  logic [AW-1:0]     pos_addr;
  logic              pos_we;
  logic [POSM-1:0]   pos_rdata_r;
  logic [POSM-1:0]   pa_r, pb_r;

  logic [ACC_W-1:0]  acc_mem [MAX_VERTICES];
  logic [AW-1:0]     acc_addr;
  logic              acc_we;
  logic [ACC_W-1:0]  acc_wdata;
  logic [ACC_W-1:0]  acc_rdata_r;
  logic [SW:0]       upd_x, upd_y, upd_z;

  vna_pkg::unit_stat_t       cross_stat, norm_stat;
  logic signed [CW-1:0]      cross_x, cross_y, cross_z;
  logic signed [NW-1:0]      norm_x, norm_y, norm_z;
  logic                      clip_r;
  logic                      out_valid_r;
  logic [NW-1:0]             out_x_r, out_y_r, out_z_r;
  logic                      out_clip_r;
  logic                      out_load;

  // Saturating add of a cross product into one sum; the top bit flags a clip.
  function automatic logic [SW:0] sat_add(input logic [SW-1:0] acc,
                                          input logic [CW-1:0] add);
    logic [SW:0] s;
    s = {acc[SW-1], acc} + {{(SW + 1 - CW){add[CW-1]}}, add};
    if (s[SW] != s[SW-1]) begin
      sat_add = {1'b1, s[SW], {(SW - 1){~s[SW]}}};
    end else begin
      sat_add = {1'b0, s[SW-1:0]};
    end
  endfunction

  // Index range checks on the incoming beat.
  assign ext_a   = XW'(in_index_a);
  assign ext_b   = XW'(in_index_b);
  assign ext_c   = XW'(in_index_c);
  assign ok_a    = ({20'd0, in_index_a} < 32'(MAX_VERTICES));
  assign ok_b    = ({20'd0, in_index_b} < 32'(MAX_VERTICES));
  assign ok_c    = ({20'd0, in_index_c} < 32'(MAX_VERTICES));
  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_func == vna_pkg::FUNC_FACE && ok_a && ok_b && ok_c) begin
            state_nxt = S_PB;
          end else if (in_func == vna_pkg::FUNC_READ && ok_a) begin
            state_nxt = S_RACC;
          end
        end
      end
      S_PB:    state_nxt = S_PC;
      S_PC:    state_nxt = S_PW;
      S_PW:    state_nxt = S_CROSS;
      S_CROSS: if (cross_stat.done) state_nxt = S_ARD;
      S_ARD:   state_nxt = S_AWR;
      S_AWR:   state_nxt = (corner_r == 2'd2) ? S_IDLE : S_ARD;
      S_RACC:  state_nxt = S_RNORM;
      S_RNORM: if (norm_stat.done) state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      corner_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_CROSS) begin
        corner_r <= '0;
      end else if (state_r == S_AWR) begin
        corner_r <= corner_r + 2'd1;
      end
    end
  end

  // Latch the indexes of the beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_a_r <= ext_a[AW-1:0];
      idx_b_r <= ext_b[AW-1:0];
      idx_c_r <= ext_c[AW-1:0];
    end
  end

  always_comb begin
    case (corner_r)
      2'd0:    corner_idx = idx_a_r;
      2'd1:    corner_idx = idx_b_r;
      default: corner_idx = idx_c_r;
    endcase
  end

  // Position memory: one port, read data registered.
  always_comb begin
    case (state_r)
      S_IDLE:  pos_addr = ext_a[AW-1:0];
      S_PB:    pos_addr = idx_b_r;
      S_PC:    pos_addr = idx_c_r;
      default: pos_addr = idx_a_r;
    endcase
  end
  assign pos_we = in_fire && in_func == vna_pkg::FUNC_LOAD && ok_a;

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_addr] <= {in_pos_in_x, in_pos_in_y, in_pos_in_z};
    pos_rdata_r <= pos_mem[pos_addr];
  end

  // Corner positions collected for the cross product.
  always_ff @(posedge clk) begin
    if (state_r == S_PB) pa_r <= pos_rdata_r;
    if (state_r == S_PC) pb_r <= pos_rdata_r;
  end

  vna_cross u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == S_PW),
    .pos_a   (pa_r),
    .pos_b   (pb_r),
    .pos_c   (pos_rdata_r),
    .stat    (cross_stat),
    .cross_x (cross_x),
    .cross_y (cross_y),
    .cross_z (cross_z)
  );

  // Sum memory: {clip, sum_x, sum_y, sum_z}, read-modify-write one corner at a time.
  assign upd_x = sat_add(acc_rdata_r[3*SW-1:2*SW], cross_x);
  assign upd_y = sat_add(acc_rdata_r[2*SW-1:SW],   cross_y);
  assign upd_z = sat_add(acc_rdata_r[SW-1:0],      cross_z);

  always_comb begin
    case (state_r)
      S_IDLE:  acc_addr = ext_a[AW-1:0];
      S_ARD:   acc_addr = corner_idx;
      S_AWR:   acc_addr = corner_idx;
      default: acc_addr = idx_a_r;
    endcase
  end
  assign acc_we    = pos_we || (state_r == S_AWR);
  assign acc_wdata = (state_r == S_AWR)
                   ? {acc_rdata_r[3*SW] | upd_x[SW] | upd_y[SW] | upd_z[SW],
                      upd_x[SW-1:0], upd_y[SW-1:0], upd_z[SW-1:0]}
                   : '0;

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_addr] <= acc_wdata;
    acc_rdata_r <= acc_mem[acc_addr];
  end

  // Normalization of a read sum.
  always_ff @(posedge clk) begin
    if (state_r == S_RACC) clip_r <= acc_rdata_r[3*SW];
  end

  vna_norm #(.SUM_WIDTH(SUM_WIDTH)) u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_RACC),
    .sum_x  (acc_rdata_r[3*SW-1:2*SW]),
    .sum_y  (acc_rdata_r[2*SW-1:SW]),
    .sum_z  (acc_rdata_r[SW-1:0]),
    .stat   (norm_stat),
    .norm_x (norm_x),
    .norm_y (norm_y),
    .norm_z (norm_z)
  );

  // Output register.
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r    <= norm_x;
      out_y_r    <= norm_y;
      out_z_r    <= norm_z;
      out_clip_r <= clip_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_normal_x    = out_x_r;
  assign out_normal_y    = out_y_r;
  assign out_normal_z    = out_z_r;
  assign out_sum_clipped = out_clip_r;

`ifndef SYNTH
  // The cross product finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    cross_stat.done |-> state_r == S_CROSS)
    else $error("cross product finished outside its wait state");

  // A normal finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    norm_stat.done |-> state_r == S_RNORM)
    else $error("normalization finished outside its wait state");

  // Sum memory writes come only from a load or a corner update.
  assert property (@(posedge clk) disable iff (!rst_n)
    acc_we |-> (state_r == S_IDLE || state_r == S_AWR))
    else $error("unexpected sum memory write");
`endif

endmodule

>>> src/vna_cross.sv
module vna_cross (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [3*vna_pkg::POS_W-1:0]            pos_a,
  input  logic [3*vna_pkg::POS_W-1:0]            pos_b,
  input  logic [3*vna_pkg::POS_W-1:0]            pos_c,
  output vna_pkg::unit_stat_t                    stat,
  output logic signed [vna_pkg::CROSS_W-1:0]     cross_x,
  output logic signed [vna_pkg::CROSS_W-1:0]     cross_y,
  output logic signed [vna_pkg::CROSS_W-1:0]     cross_z
);

  localparam int PW = vna_pkg::POS_W;
  localparam int DW = vna_pkg::DIFF_W;
  localparam int MW = vna_pkg::PROD_W;
  localparam int CW = vna_pkg::CROSS_W;

  logic signed [DW-1:0] ux_r, uy_r, uz_r, wx_r, wy_r, wz_r;
  logic signed [DW-1:0] op_a, op_b;
  logic signed [MW-1:0] prod_r;
  logic signed [CW-1:0] prod_ext;
  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic [2:0]           step_r;
  logic                 busy_r, done_r;

  // Edge differences, sign extended to 25 bits.
  function automatic logic signed [DW-1:0] diff(input logic [PW-1:0] p,
                                                input logic [PW-1:0] q);
    diff = $signed({p[PW-1], p}) - $signed({q[PW-1], q});
  endfunction

  // One product per step from the shared multiplier.
  always_comb begin
    case (step_r)
      3'd0: begin op_a = uy_r; op_b = wz_r; end
      3'd1: begin op_a = uz_r; op_b = wy_r; end
      3'd2: begin op_a = uz_r; op_b = wx_r; end
      3'd3: begin op_a = ux_r; op_b = wz_r; end
      3'd4: begin op_a = ux_r; op_b = wy_r; end
      3'd5: begin op_a = uy_r; op_b = wx_r; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod_ext = $signed({prod_r[MW-1], prod_r});

  // Control: seven steps, the products trail the multiplier through the product register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == 3'd6) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  // Datapath: differences, product register and the three sums.
  always_ff @(posedge clk) begin
    if (start) begin
      ux_r <= diff(pos_b[3*PW-1:2*PW], pos_a[3*PW-1:2*PW]);
      uy_r <= diff(pos_b[2*PW-1:PW],   pos_a[2*PW-1:PW]);
      uz_r <= diff(pos_b[PW-1:0],      pos_a[PW-1:0]);
      wx_r <= diff(pos_c[3*PW-1:2*PW], pos_a[3*PW-1:2*PW]);
      wy_r <= diff(pos_c[2*PW-1:PW],   pos_a[2*PW-1:PW]);
      wz_r <= diff(pos_c[PW-1:0],      pos_a[PW-1:0]);
    end else if (busy_r) begin
      prod_r <= op_a * op_b;
      case (step_r)
        3'd1: cx_r <= prod_ext;
        3'd2: cx_r <= cx_r - prod_ext;
        3'd3: cy_r <= prod_ext;
        3'd4: cy_r <= cy_r - prod_ext;
        3'd5: cz_r <= prod_ext;
        3'd6: cz_r <= cz_r - prod_ext;
        default: ;
      endcase
    end
  end

  assign stat    = '{busy: busy_r, done: done_r};
  assign cross_x = cx_r;
  assign cross_y = cy_r;
  assign cross_z = cz_r;

endmodule

>>> src/vna_norm.sv
module vna_norm #(
  parameter int SUM_WIDTH = 56
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [SUM_WIDTH-1:0]                sum_x,
  input  logic [SUM_WIDTH-1:0]                sum_y,
  input  logic [SUM_WIDTH-1:0]                sum_z,
  output vna_pkg::unit_stat_t                 stat,
  output logic signed [vna_pkg::NORM_W-1:0]   norm_x,
  output logic signed [vna_pkg::NORM_W-1:0]   norm_y,
  output logic signed [vna_pkg::NORM_W-1:0]   norm_z
);

  localparam int SW = SUM_WIDTH;
  localparam int MW = vna_pkg::MAG_W;
  localparam int NW = vna_pkg::NORM_W;
  localparam int QW = 15;
  localparam int NUMW = MW + 15;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DLD   = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;

  logic [2:0]          state_r;
  logic [SW-1:0]       mag_r [3];
  logic [2:0]          neg_r;
  logic [3:0]          cnt_r;
  logic [1:0]          comp_r;
  logic [2*MW-1:0]     sq_r;
  logic [2*MW+1:0]     ss_r;
  logic [63:0]         x_r, res_r, bit_r;
  logic [MW:0]         len;
  logic [MW:0]         rem_r;
  logic [14:0]         nlow_r;
  logic [QW-1:0]       q_r;
  logic [NW-1:0]       nrm_r [3];
  logic                done_r;
  logic [MW-1:0]       cur_mag;
  logic [NUMW-1:0]     num;
  logic [MW+1:0]       rem2;
  logic [MW+1:0]       rem_sub;
  logic                ge;
  logic [QW-1:0]       q_fin;
  logic [63:0]         trial;
  logic                any_high;

  function automatic logic [SW-1:0] mag_of(input logic [SW-1:0] s);
    mag_of = s[SW-1] ? (~s + 1'b1) : s;
  endfunction

  assign len      = res_r[MW:0];
  assign cur_mag  = mag_r[comp_r][MW-1:0];
  assign num      = NUMW'({cur_mag, 14'd0}) + NUMW'(len[MW:1]);
  assign rem2     = {rem_r, nlow_r[14]};
  assign rem_sub  = rem2 - {1'b0, len};
  assign ge       = (rem2 >= {1'b0, len});
  assign q_fin    = {q_r[QW-2:0], ge};
  assign trial    = res_r + bit_r;
  assign any_high = (|mag_r[0][SW-1:MW]) | (|mag_r[1][SW-1:MW]) | (|mag_r[2][SW-1:MW]);

  // Sequencer: shift into range, sum of squares, square root, three divisions; a zero sum skips them all.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (start) begin
            if (sum_x == '0 && sum_y == '0 && sum_z == '0) begin
              done_r <= 1'b1;
            end else begin
              state_r <= N_SHIFT;
            end
          end
        end
        N_SHIFT: if (!any_high) state_r <= N_SQ;
        N_SQ: if (cnt_r == 4'd3) state_r <= N_SQRT;
        N_SQRT: if (bit_r == '0) state_r <= N_DLD;
        N_DLD: state_r <= N_DIV;
        N_DIV: begin
          if (cnt_r == 4'd0) begin
            if (comp_r == 2'd2) begin
              state_r <= N_IDLE;
              done_r  <= 1'b1;
            end else begin
              state_r <= N_DLD;
            end
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      N_IDLE: begin
        if (start) begin
          mag_r[0] <= mag_of(sum_x);
          mag_r[1] <= mag_of(sum_y);
          mag_r[2] <= mag_of(sum_z);
          neg_r    <= {sum_z[SW-1], sum_y[SW-1], sum_x[SW-1]};
          nrm_r[0] <= '0;
          nrm_r[1] <= '0;
          nrm_r[2] <= '0;
          cnt_r    <= '0;
          ss_r     <= '0;
        end
      end
      N_SHIFT: begin
        if (any_high) begin
          mag_r[0] <= mag_r[0] >> 1;
          mag_r[1] <= mag_r[1] >> 1;
          mag_r[2] <= mag_r[2] >> 1;
        end
      end
      N_SQ: begin
        // The square lands in the cycle after its operand is chosen.
        if (cnt_r != 4'd3) sq_r <= mag_r[cnt_r[1:0]][MW-1:0] * mag_r[cnt_r[1:0]][MW-1:0];
        if (cnt_r != 4'd0) ss_r <= ss_r + (2*MW+2)'(sq_r);
        if (cnt_r == 4'd3) begin
          x_r   <= 64'(ss_r + (2*MW+2)'(sq_r));
          res_r <= '0;
          bit_r <= 64'd1 << 62;
        end
        cnt_r <= cnt_r + 4'd1;
      end
      N_SQRT: begin
        if (bit_r != '0) begin
          if (x_r >= trial) begin
            x_r   <= x_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end else begin
          comp_r <= '0;
        end
      end
      N_DLD: begin
        rem_r  <= {1'b0, num[NUMW-1:15]};
        nlow_r <= num[14:0];
        q_r    <= '0;
        cnt_r  <= 4'd14;
      end
      N_DIV: begin
        rem_r  <= ge ? rem_sub[MW:0] : rem2[MW:0];
        nlow_r <= {nlow_r[13:0], 1'b0};
        q_r    <= q_fin;
        cnt_r  <= cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          nrm_r[comp_r] <= neg_r[comp_r] ? (~{1'b0, q_fin} + 1'b1) : {1'b0, q_fin};
          comp_r        <= comp_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign stat   = '{busy: (state_r != N_IDLE), done: done_r};
  assign norm_x = nrm_r[0];
  assign norm_y = nrm_r[1];
  assign norm_z = nrm_r[2];

endmodule

>>> test/vertex_normal_accumulator_core_test.sv
module vertex_normal_accumulator_core_test;

  localparam int IW = vna_pkg::IDX_W;
  localparam int PW = vna_pkg::POS_W;
  localparam int NW = vna_pkg::NORM_W;
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int NUM_VERTS = 4096;
  localparam longint SUM_MAX = (64'sd1 <<< 55) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic signed [PW-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [PW-1:0] POS_MIN = -24'sh800000;

  typedef struct {
    logic [NW-1:0] nx;
    logic [NW-1:0] ny;
    logic [NW-1:0] nz;
    logic          clip;
  } normal_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_func;
  logic [IW-1:0] in_index_a, in_index_b, in_index_c;
  logic signed [PW-1:0] in_pos_in_x, in_pos_in_y, in_pos_in_z;
  logic out_valid;
  logic out_stall;
  logic signed [NW-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_sum_clipped;

  // Shadow copy of the vertex and sum memories.
  longint vert_x [NUM_VERTS];
  longint vert_y [NUM_VERTS];
  longint vert_z [NUM_VERTS];
  longint acc_x [NUM_VERTS];
  longint acc_y [NUM_VERTS];
  longint acc_z [NUM_VERTS];
  bit     acc_clip [NUM_VERTS];
  bit     loaded [NUM_VERTS];
  int     loaded_list [$];

  normal_t pending_normals [$];
  int errors = 0;
  int cycles = 0;
  int beats_sent;
  int normals_seen = 0;
  int clipped_seen = 0;

  vertex_normal_accumulator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_index_a(in_index_a), .in_index_b(in_index_b), .in_index_c(in_index_c),
    .in_pos_in_x(in_pos_in_x), .in_pos_in_y(in_pos_in_y), .in_pos_in_z(in_pos_in_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_sum_clipped(out_sum_clipped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturating add into one accumulator component.
  function automatic longint sat_add(input longint acc, input longint add,
                                     inout bit clip);
    longint total;
    total = acc + add;
    if (total > SUM_MAX) begin
      clip = 1'b1;
      return SUM_MAX;
    end
    if (total < SUM_MIN) begin
      clip = 1'b1;
      return SUM_MIN;
    end
    return total;
  endfunction

  function automatic void add_to_corner(input int v, input longint cx,
                                        input longint cy, input longint cz);
    bit clip;
    clip = acc_clip[v];
    acc_x[v] = sat_add(acc_x[v], cx, clip);
    acc_y[v] = sat_add(acc_y[v], cy, clip);
    acc_z[v] = sat_add(acc_z[v], cz, clip);
    acc_clip[v] = clip;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag_of(input longint s);
    return s < 0 ? longint'(-s) : longint'(s);
  endfunction

  function automatic logic [NW-1:0] scale_component(input longint s, input int k,
                                                    input longint unsigned len);
    longint unsigned q;
    q = ((mag_of(s) >> k) * 16384 + len / 2) / len;
    if (s < 0) q = -q;
    return q[NW-1:0];
  endfunction

  // Unit normal of the accumulated face sum at one vertex.
  function automatic normal_t predict_normal(input int v);
    normal_t r;
    longint unsigned mx, my, mz, m, len;
    int k;
    mx = mag_of(acc_x[v]);
    my = mag_of(acc_y[v]);
    mz = mag_of(acc_z[v]);
    m = mx;
    if (my > m) m = my;
    if (mz > m) m = mz;
    r.clip = acc_clip[v];
    r.nx = '0;
    r.ny = '0;
    r.nz = '0;
    if (m == 0) return r;
    k = 0;
    while ((m >> k) >= (64'd1 << vna_pkg::MAG_W)) k++;
    mx >>= k;
    my >>= k;
    mz >>= k;
    len = int_sqrt(mx * mx + my * my + mz * mz);
    r.nx = scale_component(acc_x[v], k, len);
    r.ny = scale_component(acc_y[v], k, len);
    r.nz = scale_component(acc_z[v], k, len);
    return r;
  endfunction

  // Update the shadow state for one accepted beat.
  function automatic void predict_beat(input logic [1:0] f, input int a, input int b,
                                       input int c, input longint px, input longint py,
                                       input longint pz);
    longint ux, uy, uz, wx, wy, wz;
    case (f)
      vna_pkg::FUNC_LOAD: begin
        vert_x[a] = px;
        vert_y[a] = py;
        vert_z[a] = pz;
        acc_x[a] = 0;
        acc_y[a] = 0;
        acc_z[a] = 0;
        acc_clip[a] = 1'b0;
        if (!loaded[a]) loaded_list = {loaded_list, a};
        loaded[a] = 1'b1;
      end
      vna_pkg::FUNC_FACE: begin
        ux = vert_x[b] - vert_x[a];
        uy = vert_y[b] - vert_y[a];
        uz = vert_z[b] - vert_z[a];
        wx = vert_x[c] - vert_x[a];
        wy = vert_y[c] - vert_y[a];
        wz = vert_z[c] - vert_z[a];
        add_to_corner(a, uy * wz - uz * wy, uz * wx - ux * wz, ux * wy - uy * wx);
        add_to_corner(b, uy * wz - uz * wy, uz * wx - ux * wz, ux * wy - uy * wx);
        add_to_corner(c, uy * wz - uz * wy, uz * wx - ux * wz, ux * wy - uy * wx);
      end
      vna_pkg::FUNC_READ: begin
        pending_normals = {pending_normals, predict_normal(a)};
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one beat, wait for it to be taken, then maybe idle.
  task automatic send_beat(input logic [1:0] f, input logic [IW-1:0] a,
                           input logic [IW-1:0] b, input logic [IW-1:0] c,
                           input logic signed [PW-1:0] px,
                           input logic signed [PW-1:0] py,
                           input logic signed [PW-1:0] pz, input bit allow_gap);
    int gap;
    in_valid <= 1'b1;
    in_func <= f;
    in_index_a <= a;
    in_index_b <= b;
    in_index_c <= c;
    in_pos_in_x <= px;
    in_pos_in_y <= py;
    in_pos_in_z <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(f, int'(a), int'(b), int'(c), longint'(px), longint'(py), longint'(pz));
    beats_sent++;
    gap = allow_gap ? gap_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_vertex(input int v, input logic signed [PW-1:0] px,
                             input logic signed [PW-1:0] py,
                             input logic signed [PW-1:0] pz);
    send_beat(vna_pkg::FUNC_LOAD, IW'(v), IW'($urandom), IW'($urandom), px, py, pz, 1'b1);
  endtask

  task automatic add_face(input int a, input int b, input int c, input bit allow_gap);
    send_beat(vna_pkg::FUNC_FACE, IW'(a), IW'(b), IW'(c), PW'($urandom), PW'($urandom),
              PW'($urandom), allow_gap);
  endtask

  task automatic read_normal(input int v);
    send_beat(vna_pkg::FUNC_READ, IW'(v), IW'($urandom), IW'($urandom), PW'($urandom),
              PW'($urandom), PW'($urandom), 1'b1);
  endtask

  function automatic logic signed [PW-1:0] random_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return PW'($urandom);
    if (r < 3) return $urandom_range(0, 1) ? POS_MAX : POS_MIN;
    return $signed(24'($urandom_range(0, 4095))) - 24'sd2048;
  endfunction

  task automatic report_mismatch(input string what, input logic [NW-1:0] got,
                                 input logic [NW-1:0] want);
    errors++;
    $display("mismatch on %s: got %0h, expected %0h (normal %0d)", what, got, want,
             normals_seen);
  endtask

  // Random back-pressure on the result side, with quiet stretches.
  int stall_left;
  int quiet_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      quiet_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (quiet_left > 0) begin
      quiet_left <= quiet_left - 1;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 9) < 3) begin
      stall_left <= gap_length();
      out_stall <= 1'b1;
    end else begin
      quiet_left <= $urandom_range(0, 1) ? $urandom_range(20, 200) : 0;
      out_stall <= 1'b0;
    end
  end

  // Compare each normal taken with the oldest one predicted.
  always @(posedge clk) begin
    normal_t want;
    if (rst_n && out_valid && !out_stall) begin
      normals_seen++;
      if (out_sum_clipped) clipped_seen++;
      if (pending_normals.size() == 0) begin
        report_mismatch("unexpected normal beat", out_normal_x, '0);
      end else begin
        want = pending_normals.pop_front();
        if (out_normal_x !== want.nx) report_mismatch("normal_x", out_normal_x, want.nx);
        if (out_normal_y !== want.ny) report_mismatch("normal_y", out_normal_y, want.ny);
        if (out_normal_z !== want.nz) report_mismatch("normal_z", out_normal_z, want.nz);
        if (out_sum_clipped !== want.clip) report_mismatch("sum_clipped",
                                                           NW'(out_sum_clipped),
                                                           NW'(want.clip));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** vertex_normal_accumulator_core: FAILED **");
      $finish;
    end
  end

  // Extreme fields, each function code, zero sum, shared corners.
  task automatic test_directed();
    load_vertex(0, POS_MIN, POS_MIN, POS_MIN);
    load_vertex(4095, POS_MAX, POS_MAX, POS_MAX);
    load_vertex(2730, POS_MAX, POS_MIN, 24'sd0);
    load_vertex(1365, 24'sd0, POS_MAX, POS_MIN);
    read_normal(0);
    add_face(0, 4095, 2730, 1'b1);
    add_face(1365, 2730, 4095, 1'b1);
    read_normal(0);
    read_normal(4095);
    read_normal(2730);
    read_normal(1365);
    add_face(0, 0, 4095, 1'b1);
    add_face(2730, 2730, 2730, 1'b1);
    read_normal(2730);
    send_beat(FUNC_NOP, 12'hFFF, 12'hFFF, 12'hFFF, POS_MAX, POS_MIN, POS_MAX, 1'b1);
    send_beat(FUNC_NOP, 12'h000, 12'h000, 12'h000, POS_MIN, POS_MAX, POS_MIN, 1'b1);
    load_vertex(4095, 24'sd1, 24'sd0, 24'sd0);
    read_normal(4095);
    load_vertex(7, 24'sd0, 24'sd0, 24'sd0);
    load_vertex(8, 24'sd1, 24'sd0, 24'sd0);
    load_vertex(9, 24'sd0, 24'sd1, 24'sd0);
    add_face(7, 8, 9, 1'b1);
    read_normal(7);
    read_normal(9);
  endtask

  // Drive the sums into saturation both ways, clearing by reloading in between.
  task automatic test_saturation();
    load_vertex(100, POS_MIN, POS_MIN, POS_MIN);
    load_vertex(101, POS_MAX, POS_MIN, POS_MIN);
    load_vertex(102, POS_MIN, POS_MAX, POS_MIN);
    for (int i = 0; i < 140; i++) add_face(100, 101, 102, i % 16 == 0);
    read_normal(100);
    read_normal(101);
    load_vertex(100, POS_MIN, POS_MIN, POS_MIN);
    load_vertex(101, POS_MAX, POS_MIN, POS_MIN);
    load_vertex(102, POS_MIN, POS_MAX, POS_MIN);
    for (int i = 0; i < 140; i++) add_face(100, 102, 101, i % 16 == 0);
    read_normal(102);
    load_vertex(100, POS_MIN, POS_MIN, POS_MIN);
    read_normal(100);
  endtask

  // Mostly small meshes with random contents, some noise.
  task automatic test_random(input int n);
    int r;
    int a, b, c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      b = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      c = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      if (r < 25) begin
        if ($urandom_range(0, 1)) a = $urandom_range(0, NUM_VERTS - 1);
        load_vertex(a, random_pos(), random_pos(), random_pos());
      end else if (r < 65) begin
        add_face(a, b, c, 1'b1);
      end else if (r < 95) begin
        read_normal(a);
      end else begin
        send_beat(FUNC_NOP, IW'($urandom), IW'($urandom), IW'($urandom), PW'($urandom),
                  PW'($urandom), PW'($urandom), 1'b1);
      end
    end
  endtask

  initial begin
    beats_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = vna_pkg::FUNC_LOAD;
    in_index_a = '0;
    in_index_b = '0;
    in_index_c = '0;
    in_pos_in_x = '0;
    in_pos_in_y = '0;
    in_pos_in_z = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_saturation();
    test_random(190);
    in_valid <= 1'b0;

    // Drain, then allow an in-flight face to finish.
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("sent %0d beats over %0d loaded vertices; checked %0d normals, %0d clipped",
             beats_sent, loaded_list.size(), normals_seen, clipped_seen);
    $display("%0d mismatches", errors);
    if (errors == 0) begin
      $display("** vertex_normal_accumulator_core: PASSED **");
    end else begin
      $display("** vertex_normal_accumulator_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> vertex_normal_accumulator_core.f
src/vna_pkg.sv
src/vna_cross.sv
src/vna_norm.sv
src/vertex_normal_accumulator_core.sv
test/vertex_normal_accumulator_core_test.sv
